>>> src/cfs_pkg.sv
// Shared types and constants for the circular FIFO with content search.
`default_nettype none
package cfs_pkg;

  localparam int DataW = 32;
  localparam int OpW   = 2;
  localparam int StW   = 2;
  localparam int OffW  = 3;

  localparam logic [OpW-1:0] OpEnq  = 2'd0;
  localparam logic [OpW-1:0] OpDeq  = 2'd1;
  localparam logic [OpW-1:0] OpFind = 2'd2;

  localparam logic [StW-1:0] StOk    = 2'd0;
  localparam logic [StW-1:0] StFull  = 2'd1;
  localparam logic [StW-1:0] StEmpty = 2'd2;

  // Value returned by a dequeue from an empty queue (-1).
  localparam logic [DataW-1:0] DeqEmptyVal = 32'hFFFF_FFFF;

  typedef struct packed {
    logic            found;
    logic [OffW-1:0] offset;
  } find_t;

  typedef struct packed {
    logic [StW-1:0]   status;
    logic [DataW-1:0] data_out;
    logic             found;
    logic [OffW-1:0]  match_offset;
  } res_t;

endpackage
`default_nettype wire

>>> src/cfs_cell.sv
// One storage cell of the FIFO chain: holds one word, shifts toward the head, compares.
`default_nettype none
module cfs_cell (
  input  wire logic                     clk_i,
  input  wire logic                     load_i,
  input  wire logic                     shift_i,
  input  wire logic [cfs_pkg::DataW-1:0] din_i,
  input  wire logic [cfs_pkg::DataW-1:0] nbr_i,
  input  wire logic [cfs_pkg::DataW-1:0] key_i,
  output logic      [cfs_pkg::DataW-1:0] data_o,
  output logic                          match_o
);

  logic [cfs_pkg::DataW-1:0] data_q;

  // no reset: contents are only read once written
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= din_i;
    end else if (shift_i) begin
      data_q <= nbr_i;
    end
  end

  assign data_o  = data_q;
  assign match_o = (data_q == key_i);

endmodule
`default_nettype wire

>>> src/cfs_prio.sv
// First-match encoder over the registered match vector (lowest offset wins).
`default_nettype none
module cfs_prio #(
  parameter int Depth = 8
) (
  input  wire logic [Depth-1:0] match_i,
  output cfs_pkg::find_t        find_o
);

  localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int ExtW = (IdxW > cfs_pkg::OffW) ? IdxW : cfs_pkg::OffW;

  logic            hit;
  logic [IdxW-1:0] idx;
  logic [ExtW-1:0] idx_ext;

  always_comb begin
    hit = 1'b0;
    idx = '0;
    for (int i = Depth - 1; i >= 0; i--) begin
      if (match_i[i]) begin
        hit = 1'b1;
        idx = IdxW'(i);
      end
    end
  end

  // only the low offset bits are reported
  assign idx_ext       = ExtW'(idx);
  assign find_o.found  = hit;
  assign find_o.offset = idx_ext[cfs_pkg::OffW-1:0];

endmodule
`default_nettype wire

>>> src/circular_fifo_with_search.sv
// Top level: circular FIFO with content search, built as a shifting chain of cells.
// A result goes through the pending stage and then the output register to the master side.
// Throughput: one command per cycle while the master side keeps tready high.
// Find compares every cell in parallel; the matches are registered, then first-match encoded.
// Reset: asynchronous, active low; queue empty, no result pending. Cell data is not reset.
`default_nettype none
module circular_fifo_with_search #(
  parameter int DEPTH = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave side
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // [31:0] data_in
  input  wire logic [1:0]  s_axis_tuser_i,   // [1:0] op
  // master side
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [39:0] m_axis_tdata_o,   // [31:0] data_out, [32] found,
                                             // [35:33] match_offset, [39:36] zero
  output logic      [1:0]  m_axis_tuser_o    // [1:0] status
);

  localparam int CntW = $clog2(DEPTH + 1);

  // ---------------------------------------------------------------------------
  // Occupancy. The oldest entry always lives in cell 0; the chain shifts on a
  // dequeue, so no head pointer is needed.
  // ---------------------------------------------------------------------------
  logic [CntW-1:0] count_q, count_d;

  logic in_fire;
  logic [cfs_pkg::OpW-1:0]   in_op;
  logic [cfs_pkg::DataW-1:0] in_data;
  logic is_empty, is_full;
  logic enq_ok, deq_ok;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign in_op    = s_axis_tuser_i;
  assign in_data  = s_axis_tdata_i;
  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CntW'(DEPTH));
  assign enq_ok   = in_fire && (in_op == cfs_pkg::OpEnq) && !is_full;
  assign deq_ok   = in_fire && (in_op == cfs_pkg::OpDeq) && !is_empty;

  always_comb begin
    count_d = count_q;
    if (enq_ok) begin
      count_d = count_q + CntW'(1);
    end else if (deq_ok) begin
      count_d = count_q - CntW'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Cell chain
  // ---------------------------------------------------------------------------
  logic [cfs_pkg::DataW-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]          cell_match;
  logic [DEPTH-1:0]          occ_match;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [cfs_pkg::DataW-1:0] nbr;
    if (g < DEPTH - 1) begin : g_mid
      assign nbr = cell_data[g+1];
    end else begin : g_last
      assign nbr = cell_data[g];
    end

    cfs_cell u_cell (
      .clk_i   (clk_i),
      .load_i  (enq_ok && (count_q == CntW'(g))),
      .shift_i (deq_ok),
      .din_i   (in_data),
      .nbr_i   (nbr),
      .key_i   (in_data),
      .data_o  (cell_data[g]),
      .match_o (cell_match[g])
    );

    // only occupied cells take part in a search
    assign occ_match[g] = cell_match[g] && (count_q > CntW'(g));
  end

  // ---------------------------------------------------------------------------
  // Pending stage: holds one transaction's partial result and the match vector
  // ---------------------------------------------------------------------------
  logic               p_valid_q;
  logic               p_find_q;
  cfs_pkg::res_t      p_res_q, p_res_d;
  logic [DEPTH-1:0]   p_match_q;
  logic               load_out;

  cfs_pkg::find_t     find;
  cfs_pkg::res_t      out_res_q, out_res_d;
  logic               out_valid_q;

  assign load_out        = p_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !p_valid_q || load_out;

  always_comb begin
    p_res_d = '{status: cfs_pkg::StOk, data_out: '0, found: 1'b0, match_offset: '0};
    case (in_op)
      cfs_pkg::OpEnq: begin
        if (is_full) p_res_d.status = cfs_pkg::StFull;
      end
      cfs_pkg::OpDeq: begin
        if (is_empty) begin
          p_res_d.status   = cfs_pkg::StEmpty;
          p_res_d.data_out = cfs_pkg::DeqEmptyVal;
        end else begin
          p_res_d.data_out = cell_data[0];
        end
      end
      cfs_pkg::OpFind: begin
        if (is_empty) p_res_d.status = cfs_pkg::StEmpty;
      end
      default: ;  // unused op: all-zero result
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      p_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_fire) begin
        p_valid_q <= 1'b1;
      end else if (load_out) begin
        p_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      p_find_q  <= (in_op == cfs_pkg::OpFind);
      p_res_q   <= p_res_d;
      p_match_q <= occ_match;
    end
  end

  // ---------------------------------------------------------------------------
  // First-match encode and output register
  // ---------------------------------------------------------------------------
  cfs_prio #(
    .Depth (DEPTH)
  ) u_prio (
    .match_i (p_match_q),
    .find_o  (find)
  );

  always_comb begin
    out_res_d = p_res_q;
    if (p_find_q) begin
      // an empty queue leaves the match vector all zero
      out_res_d.found        = find.found;
      out_res_d.match_offset = find.found ? find.offset : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_res_q <= out_res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_res_q.status;
  assign m_axis_tdata_o  = {4'b0000, out_res_q.match_offset, out_res_q.found,
                            out_res_q.data_out};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("fill count above depth");

  a_enq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enq_ok |=> count_q == $past(count_q) + CntW'(1))
    else $error("enqueue did not grow the queue");

  a_deq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq_ok |=> count_q == $past(count_q) - CntW'(1))
    else $error("dequeue did not shrink the queue");

  a_find_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && out_res_d.found) |-> (out_res_d.status == cfs_pkg::StOk && p_find_q))
    else $error("match reported on a non-search or failed transaction");

  a_match_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (p_match_q & ~$past(occ_match)) == '0)
    else $error("match vector holds an unoccupied cell");

endmodule
`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for circular_fifo_with_search, built around a shadow queue predictor.
`default_nettype none
module testbench;

  localparam int Depth       = 8;
  localparam int ClkHalf     = 5;
  localparam int ResetCycles = 8;
  localparam int DrainCycles = 8;     // pipeline latency plus margin
  localparam int MaxReports  = 10;
  localparam int HoldCycles  = 100;   // long receiver hold-off for the pressure test
  localparam int WatchdogTime = 3_000_000;

  // op value 3 is unused: the block drops it and answers with an all-zero response
  localparam logic [cfs_pkg::OpW-1:0] OpIgnored = 2'd3;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;   // [31:0] data_in
  logic [1:0]  s_tuser  = '0;   // [1:0] op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;         // [31:0] data_out, [32] found, [35:33] match_offset
  logic [1:0]  m_tuser;         // [1:0] status

  // shadow copy of the queue contents
  logic [cfs_pkg::DataW-1:0] shadow_words [Depth];
  int               shadow_head  = 0;
  int               shadow_count = 0;

  cfs_pkg::res_t pending_responses [$];
  int   failures       = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   hold_left      = 0;

  circular_fifo_with_search #(.DEPTH(Depth)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  // Applies one command to the shadow queue and returns the response it must produce.
  function automatic cfs_pkg::res_t predict_response(logic [cfs_pkg::OpW-1:0] op,
                                                     logic [cfs_pkg::DataW-1:0] value);
    cfs_pkg::res_t r;
    r = '0;
    case (op)
      cfs_pkg::OpEnq: begin
        if (shadow_count == Depth) begin
          r.status = cfs_pkg::StFull;
        end else begin
          shadow_words[(shadow_head + shadow_count) % Depth] = value;
          shadow_count++;
        end
      end
      cfs_pkg::OpDeq: begin
        if (shadow_count == 0) begin
          r.status   = cfs_pkg::StEmpty;
          r.data_out = cfs_pkg::DeqEmptyVal;
        end else begin
          r.data_out  = shadow_words[shadow_head];
          shadow_head = (shadow_head + 1) % Depth;
          shadow_count--;
        end
      end
      cfs_pkg::OpFind: begin
        if (shadow_count == 0) begin
          r.status = cfs_pkg::StEmpty;
        end else begin
          // walk newest to oldest so the oldest hit is the one that sticks
          for (int k = shadow_count - 1; k >= 0; k--) begin
            if (shadow_words[(shadow_head + k) % Depth] == value) begin
              r.found        = 1'b1;
              r.match_offset = k[cfs_pkg::OffW-1:0];
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void record_failure(string what, cfs_pkg::res_t want,
                                         cfs_pkg::res_t got);
    failures++;
    if (failures <= MaxReports)
      $display("%0t: %s: exp st=%0d d=%h f=%0d o=%0d, got st=%0d d=%h f=%0d o=%0d",
               $time, what, want.status, want.data_out, want.found, want.match_offset,
               got.status, got.data_out, got.found, got.match_offset);
  endfunction

  // Offers one command until the slave side takes it, then idles per the current phase.
  task automatic send_command(logic [cfs_pkg::OpW-1:0] op, logic [cfs_pkg::DataW-1:0] value);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= value;
    do @(posedge clk_i); while (!s_tready);
    pending_responses.push_back(predict_response(op, value));
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Mix of extremes and a small pool so that duplicates turn up often.
  function automatic logic [cfs_pkg::DataW-1:0] random_word();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      4, 5, 6: return cfs_pkg::DataW'($urandom_range(15));
      default: return $urandom();
    endcase
  endfunction

  // Mostly values that sit in the queue, at any offset, so hits are common.
  function automatic logic [cfs_pkg::DataW-1:0] search_target();
    if (shadow_count != 0 && $urandom_range(99) < 60)
      return shadow_words[(shadow_head + $urandom_range(shadow_count - 1)) % Depth];
    return random_word();
  endfunction

  // Response checker and master-side ready driver.
  initial begin
    cfs_pkg::res_t got;
    cfs_pkg::res_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_tvalid && m_tready) begin
        got.status       = m_tuser;
        got.data_out     = m_tdata[31:0];
        got.found        = m_tdata[32];
        got.match_offset = m_tdata[35:33];
        if (pending_responses.size() == 0) begin
          record_failure("response with none pending", '0, got);
        end else begin
          want = pending_responses.pop_front();
          if (got.status !== want.status || got.data_out !== want.data_out ||
              got.found !== want.found || got.match_offset !== want.match_offset)
            record_failure("response mismatch", want, got);
        end
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic test_empty_queue();
    send_command(cfs_pkg::OpDeq, 32'h1234_5678);
    send_command(cfs_pkg::OpFind, 32'h0000_0000);
    send_command(OpIgnored, 32'hFFFF_FFFF);
  endtask

  task automatic test_fill_to_capacity();
    send_command(cfs_pkg::OpEnq, 32'h8000_0000);
    send_command(cfs_pkg::OpEnq, 32'h7FFF_FFFF);
    send_command(cfs_pkg::OpEnq, 32'hFFFF_FFFF);
    send_command(cfs_pkg::OpEnq, 32'h0000_0000);
    send_command(cfs_pkg::OpEnq, 32'h5555_5555);
    send_command(cfs_pkg::OpEnq, 32'hAAAA_AAAA);
    send_command(cfs_pkg::OpEnq, 32'h0000_0001);
    send_command(cfs_pkg::OpEnq, 32'h7FFF_FFFF);   // duplicate of the second entry
    send_command(cfs_pkg::OpEnq, 32'h0BAD_0BAD);   // rejected: queue full
    send_command(OpIgnored, 32'h0000_0000);
  endtask

  task automatic test_search();
    send_command(cfs_pkg::OpFind, 32'h8000_0000);  // oldest entry
    send_command(cfs_pkg::OpFind, 32'h7FFF_FFFF);  // first of two copies wins
    send_command(cfs_pkg::OpFind, 32'h0000_0001);
    send_command(cfs_pkg::OpFind, 32'h1234_5678);  // absent
  endtask

  task automatic test_wrap_around();
    repeat (4) send_command(cfs_pkg::OpDeq, 32'h0000_0000);
    send_command(cfs_pkg::OpEnq, 32'hFFFF_FFFE);
    send_command(cfs_pkg::OpEnq, 32'h0000_0002);   // lands past the end of the array
    send_command(cfs_pkg::OpFind, 32'h0000_0002);
    send_command(cfs_pkg::OpFind, 32'hFFFF_FFFE);
  endtask

  // Receiver holds off while the sender keeps offering, so the block fills and stalls.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = HoldCycles;
    while (hold_left > 0)
      send_command($urandom_range(1) ? cfs_pkg::OpEnq : cfs_pkg::OpFind, random_word());
  endtask

  task automatic test_random_traffic(int items, int idle_pct, int stall_pct);
    int  accepted;
    int  roll;
    bit  filling;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    accepted = 0;
    filling  = 1'b1;
    while (accepted < items) begin
      // drift between filling and draining so both full and empty get visited
      if ($urandom_range(19) == 0)
        filling = !filling;
      roll = $urandom_range(99);
      if (roll < 3) begin
        send_command(OpIgnored, $urandom());
      end else begin
        if (roll < 20)
          send_command(cfs_pkg::OpFind, search_target());
        else if (roll < (filling ? 75 : 40))
          send_command(cfs_pkg::OpEnq, random_word());
        else
          send_command(cfs_pkg::OpDeq, $urandom());
        accepted++;
      end
    end
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_fill_to_capacity();
    test_search();
    test_wrap_around();
    test_backpressure();
    test_random_traffic(290, 0, 0);
    test_random_traffic(290, 79, 0);
    test_random_traffic(290, 0, 79);
    test_random_traffic(290, 16, 16);

    s_tvalid <= 1'b0;
    recv_stall_pct = 0;
    for (int w = 0; w < 2000 && pending_responses.size() != 0; w++)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_responses.size() != 0) begin
      failures += pending_responses.size();
      $display("%0d responses never arrived", pending_responses.size());
    end

    if (failures == 0)
      $display("circular_fifo_with_search: match");
    else
      $display("circular_fifo_with_search: mismatch");
    $finish;
  end

  initial begin
    #WatchdogTime;
    $display("circular_fifo_with_search: mismatch");
    $finish;
  end

endmodule
`default_nettype wire

>>> circular_fifo_with_search.f
src/cfs_pkg.sv
src/cfs_cell.sv
src/cfs_prio.sv
src/circular_fifo_with_search.sv
sim/testbench.sv
